// File: hw/rtl/ilir_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ilir_pkg: shared types and constants for the indexed list block
// Holds the command codes, the beat structs of both channels and the control
// word that the top level broadcasts to the row of cells.
// ----------------------------------------------------------------------------
package ilir_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int POS_W          = 5;
  localparam int WORD_W         = 32;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_GET    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t              command;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] data_in;
  } in_t;

  typedef struct packed {
    logic              ok;
    logic [WORD_W-1:0] data_out;
    logic [POS_W-1:0]  count;
  } out_t;

  // Per-cycle control seen by every cell
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [POS_W-1:0] pos;
  } cell_ctrl_t;

endpackage : ilir_pkg
`default_nettype wire

// File: hw/rtl/ilir_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ilir_cell: one list slot
// Holds one word. On insert it loads the new word at the target position or
// takes its left neighbor above it; on remove it takes its right neighbor at
// and above the target. Drives its word on the read bus when addressed.
// ----------------------------------------------------------------------------
module ilir_cell
  import ilir_pkg::*;
#(
  parameter int IDX        = 0,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire cell_ctrl_t            ctrl,
  input  wire logic [DATA_WIDTH-1:0] new_word,
  input  wire logic [DATA_WIDTH-1:0] left_word,
  input  wire logic [DATA_WIDTH-1:0] right_word,
  output logic      [DATA_WIDTH-1:0] word_q,
  output logic      [DATA_WIDTH-1:0] rd_word
);

  logic [DATA_WIDTH-1:0] word_r;
  logic [DATA_WIDTH-1:0] word_nxt;
  logic                  hit;
  logic                  above;

  assign hit   = (int'(ctrl.pos) == IDX);
  assign above = (int'(ctrl.pos) <  IDX);

  always_comb begin
    word_nxt = word_r;
    if (ctrl.ins) begin
      if (hit) begin
        word_nxt = new_word;
      end else if (above) begin
        word_nxt = left_word;
      end
    end else if (ctrl.rem) begin
      if (hit || above) begin
        word_nxt = right_word;
      end
    end
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word_q  = word_r;
  assign rd_word = hit ? word_r : '0;

endmodule : ilir_cell
`default_nettype wire

// File: hw/rtl/indexed_list_insert_remove.sv
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_list_insert_remove: ordered list with insert/get/remove at index
// Keeps up to CAPACITY words in a row of cells plus an entry count.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_item and raise start; the beat is taken at the clock edge where
//   start is high and busy is low. busy stays low, so a new command may be
//   issued every cycle.
//   Commands: insert at position (later entries move up), get at position,
//   remove at position (later entries move down), clear all.
//   Exactly one result per command appears on out_item in the cycle after the
//   accepting edge, flagged by out_valid for a single cycle. The receiver
//   has no way to stall; it must capture the beat in that cycle.
//   Throughput is 1 command per cycle: every cell updates from its neighbors
//   in the same cycle and the addressed cell is picked off the read bus into
//   the output register.
//   A failed command (index out of range, insert into a full list) returns
//   ok low, zero data and the unchanged count.
//   Reset empties the list and drops any pending result; cell contents are
//   not cleared, the count alone marks which cells hold entries.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove
  import ilir_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_item,
  output logic      out_valid,
  output out_t      out_item
);

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int DWIDE  = (DATA_WIDTH > WORD_W) ? DATA_WIDTH : WORD_W;

  logic                  accept;
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic                  out_valid_r;
  out_t                  out_r;
  out_t                  out_nxt;
  cell_ctrl_t            ctrl;
  logic [CMP_W-1:0]      pos_ext;
  logic [CMP_W-1:0]      cnt_ext;
  logic                  ins_ok;
  logic                  rd_ok;
  logic                  full;
  logic [DATA_WIDTH-1:0] new_word;
  logic [DATA_WIDTH-1:0] rd_bus;
  logic [DATA_WIDTH-1:0] cell_q  [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_rd [CAPACITY];
  logic [CMP_W-1:0]      cnt_nxt_ext;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign pos_ext  = CMP_W'(in_item.position);
  assign cnt_ext  = CMP_W'(count_r);
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign ins_ok   = (pos_ext <= cnt_ext) && !full;
  assign rd_ok    = (pos_ext <  cnt_ext);
  assign new_word = DATA_WIDTH'(DWIDE'(in_item.data_in));

  assign ctrl.ins = accept && (in_item.command == CMD_INSERT) && ins_ok;
  assign ctrl.rem = accept && (in_item.command == CMD_REMOVE) && rd_ok;
  assign ctrl.pos = in_item.position;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w;
    logic [DATA_WIDTH-1:0] right_w;
    if (k == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_q[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right_w = cell_q[k];
    end else begin : g_mid_r
      assign right_w = cell_q[k+1];
    end
    ilir_cell #(
      .IDX        (k),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .new_word   (new_word),
      .left_word  (left_w),
      .right_word (right_w),
      .word_q     (cell_q[k]),
      .rd_word    (cell_rd[k])
    );
  end

  // at most one cell drives a nonzero word
  always_comb begin
    rd_bus = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_bus = rd_bus | cell_rd[k];
    end
  end

  always_comb begin
    count_nxt = count_r;
    out_nxt.ok       = 1'b0;
    out_nxt.data_out = '0;
    case (in_item.command)
      CMD_INSERT: begin
        if (ins_ok) begin
          count_nxt  = count_r + CNT_W'(1);
          out_nxt.ok = 1'b1;
        end
      end
      CMD_GET: begin
        if (rd_ok) begin
          out_nxt.ok       = 1'b1;
          out_nxt.data_out = WORD_W'(DWIDE'(rd_bus));
        end
      end
      CMD_REMOVE: begin
        if (rd_ok) begin
          count_nxt        = count_r - CNT_W'(1);
          out_nxt.ok       = 1'b1;
          out_nxt.data_out = WORD_W'(DWIDE'(rd_bus));
        end
      end
      CMD_CLEAR: begin
        count_nxt  = '0;
        out_nxt.ok = 1'b1;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
    cnt_nxt_ext   = CMP_W'(count_nxt);
    out_nxt.count = cnt_nxt_ext[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // hold result payload until the next beat
  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_one_result : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted command gave no result");

  a_clear_empties : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.command == CMD_CLEAR) |=> (out_item.ok && out_item.count == '0))
    else $error("clear did not empty the list");

  a_fail_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.ok) |-> (out_item.data_out == '0))
    else $error("failed command returned data");

endmodule : indexed_list_insert_remove
`default_nettype wire

// File: tb/tb_indexed_list_insert_remove.sv
// ----------------------------------------------------------------------------
// tb_indexed_list_insert_remove: self-checking bench for the indexed list
// A short directed run covers the edge cases of the list. It is followed by
// random segments that bias toward filling, draining or mixed use. A
// shadow list predicts every result, and each result beat is compared
// with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_indexed_list_insert_remove;
  import ilir_pkg::*;

  localparam int LIST_DEPTH   = CAPACITY_DEF;
  localparam int RANDOM_BEATS = 935;
  localparam int SEGMENT_LEN  = 40;
  localparam int QUIET_LO     = 350;
  localparam int QUIET_HI     = 550;
  localparam int STALL_LIMIT  = 2000;
  localparam int SETTLE_CYCLES = 4;

  typedef struct {
    in_t beat;
    bit  drain_first;
  } pending_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  in_t  in_item = '0;
  logic busy;
  logic out_valid;
  out_t out_item;

  pending_t pending_cmds[$];
  out_t     expected_results[$];

  // Shadow copy of the list
  logic [WORD_W-1:0] list_words [LIST_DEPTH];
  int                list_len;
  int                gen_len;
  int                beats_sent;
  int                fail_count;
  int                stall_cycles;

  indexed_list_insert_remove dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Apply one command to the shadow list and return the result it gives
  function automatic out_t run_list_cmd(in_t beat);
    out_t res;
    int   pos;
    res = '0;
    pos = int'(beat.position);
    case (beat.command)
      CMD_INSERT: begin
        if (pos <= list_len && list_len < LIST_DEPTH) begin
          for (int i = LIST_DEPTH - 1; i > 0; i--)
            if (i > pos && i <= list_len) list_words[i] = list_words[i-1];
          list_words[pos] = beat.data_in;
          list_len++;
          res.ok = 1'b1;
        end
      end
      CMD_GET: begin
        if (pos < list_len) begin
          res.data_out = list_words[pos];
          res.ok = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (pos < list_len) begin
          res.data_out = list_words[pos];
          for (int i = 0; i < LIST_DEPTH - 1; i++)
            if (i >= pos && i + 1 < list_len) list_words[i] = list_words[i+1];
          list_len--;
          res.ok = 1'b1;
        end
      end
      default: begin
        list_len = 0;
        res.ok = 1'b1;
      end
    endcase
    res.count = POS_W'(list_len);
    return res;
  endfunction

  // Queue a command and track the entry count it leaves behind
  task automatic queue_cmd(cmd_t cmd, int pos, logic [WORD_W-1:0] word, bit drain);
    pending_t p;
    p.beat.command  = cmd;
    p.beat.position = POS_W'(pos);
    p.beat.data_in  = word;
    p.drain_first   = drain;
    pending_cmds.push_back(p);
    case (cmd)
      CMD_INSERT: if (pos <= gen_len && gen_len < LIST_DEPTH) gen_len++;
      CMD_REMOVE: if (pos < gen_len) gen_len--;
      CMD_CLEAR:  gen_len = 0;
      default: ;
    endcase
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    int roll;
    roll = $urandom_range(99);
    if (roll < 5) return '0;
    if (roll < 10) return '1;
    return $urandom;
  endfunction

  // Driver: present the head of the queue, hold it until taken
  always @(posedge clk) begin : driver
    bit took;
    bit hold_off;
    bit drained;
    took = 1'b0;
    if (!rst_n) begin
      start   <= 1'b0;
      in_item <= '0;
    end else begin
      took = start && !busy;
      if (took) begin
        pending_cmds.delete(0);
        beats_sent++;
      end
      hold_off = (beats_sent < QUIET_LO || beats_sent >= QUIET_HI) &&
                 ($urandom_range(99) < 25);
      drained = (expected_results.size() == 0) && !took;
      if (start && !took) begin
        // hold the current beat
      end else if (pending_cmds.size() != 0 && !hold_off &&
                   (!pending_cmds[0].drain_first || drained)) begin
        start   <= 1'b1;
        in_item <= pending_cmds[0].beat;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: predict on every accepted command, check every result beat
  always @(posedge clk) begin : monitor
    out_t want;
    if (!rst_n) begin
      list_len = 0;
    end else begin
      if (start && !busy) expected_results.push_back(run_list_cmd(in_item));
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: ok %0b data %h count %0d",
                 out_item.ok, out_item.data_out, out_item.count);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_item.ok !== want.ok) begin
            $error("ok: expected %0b, got %0b", want.ok, out_item.ok);
            fail_count++;
          end
          if (out_item.data_out !== want.data_out) begin
            $error("data_out: expected %h, got %h", want.data_out, out_item.data_out);
            fail_count++;
          end
          if (out_item.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, out_item.count);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    int   mode;
    int   roll;
    int   pos;
    int   ins_cut;
    int   get_cut;
    int   rem_cut;
    cmd_t cmd;
    for (int i = 0; i < LIST_DEPTH; i++) list_words[i] = '0;
    list_len     = 0;
    gen_len      = 0;
    beats_sent   = 0;
    fail_count   = 0;
    stall_cycles = 0;
    mode         = 0;

    // Directed: empty list, past-end insert, front/middle/back edits, far positions
    queue_cmd(CMD_GET,    0,  32'h0000_0000, 1'b0);
    queue_cmd(CMD_REMOVE, 0,  32'h0000_0000, 1'b0);
    queue_cmd(CMD_INSERT, 1,  32'hDEAD_BEEF, 1'b0);
    queue_cmd(CMD_CLEAR,  0,  32'h0000_0000, 1'b0);
    queue_cmd(CMD_INSERT, 0,  32'hFFFF_FFFF, 1'b0);
    queue_cmd(CMD_INSERT, 1,  32'h0000_0000, 1'b0);
    queue_cmd(CMD_INSERT, 0,  32'hA5A5_5A5A, 1'b0);
    queue_cmd(CMD_INSERT, 1,  32'h1234_5678, 1'b0);
    queue_cmd(CMD_GET,    3,  32'hFFFF_FFFF, 1'b0);
    queue_cmd(CMD_GET,    4,  32'h0000_0000, 1'b0);
    queue_cmd(CMD_GET,    31, 32'h0000_0000, 1'b0);
    queue_cmd(CMD_INSERT, 31, 32'h5555_AAAA, 1'b0);
    queue_cmd(CMD_REMOVE, 1,  32'h0000_0000, 1'b0);
    queue_cmd(CMD_REMOVE, 2,  32'h0000_0000, 1'b0);
    queue_cmd(CMD_REMOVE, 0,  32'hFFFF_FFFF, 1'b0);
    queue_cmd(CMD_INSERT, 2,  32'h0F0F_F0F0, 1'b0);
    queue_cmd(CMD_CLEAR,  17, 32'h0000_0000, 1'b0);

    // Random segments: fill-heavy first so the full-list case comes early
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % SEGMENT_LEN == 0) mode = (n == 0) ? 0 : $urandom_range(2);
      case (mode)
        0:       begin ins_cut = 75; get_cut = 85; rem_cut = 97; end
        1:       begin ins_cut = 20; get_cut = 40; rem_cut = 97; end
        default: begin ins_cut = 40; get_cut = 65; rem_cut = 97; end
      endcase
      roll = $urandom_range(99);
      if (roll < ins_cut) cmd = CMD_INSERT;
      else if (roll < get_cut) cmd = CMD_GET;
      else if (roll < rem_cut) cmd = CMD_REMOVE;
      else cmd = CMD_CLEAR;
      roll = $urandom_range(99);
      if (roll < 85 && cmd == CMD_INSERT) pos = $urandom_range(gen_len, 0);
      else if (roll < 85 && gen_len > 0) pos = $urandom_range(gen_len - 1, 0);
      else if (roll < 95) pos = $urandom_range(LIST_DEPTH, 0);
      else pos = $urandom_range(31, 0);
      queue_cmd(cmd, pos, pick_word(), (n % 150) == 75);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
